// ----- rtl/skt_pkg.sv -----
// Shared types and constants for the sorted key table.
`default_nettype none

package skt_pkg;

  localparam int unsigned KEY_W        = 32;
  localparam int unsigned PAY_W        = 32;
  localparam int unsigned OP_W         = 3;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned MAX_RESULTS  = 16;
  localparam int unsigned CAPACITY_DEF = 16;

  // tdata widths, packed and padded to whole bytes
  localparam int unsigned IN_DATA_W  = ((KEY_W + PAY_W + 7) / 8) * 8;
  localparam int unsigned OUT_FLD_W  = COUNT_W + KEY_W + PAY_W;
  localparam int unsigned OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_SEARCH = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic     capture;  // latch compare flags against the incoming key
    cell_op_e op;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/sorted_key_table_unit.sv -----
// Sorted key table: control, result register and the chain of entry cells.
// Insert, delete, search, clear: applied in S_APPLY once the output register is free,
// result registered, then back to idle for the next request; compare flags latch in
// every cell at accept, the chain updates in S_APPLY. Read out: entries from the head,
// one per cycle plus output stalls, then the ring rotates back in place before the next request.
// Reset clears the entry count and control; cell contents are left as they are.
`default_nettype none

module sorted_key_table_unit import skt_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [31:0] key, [63:32] payload
  input  wire  [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [2:0] operation
  input  wire  [OP_W-1:0]       s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  wire                   m_axis_tready_i,
  // [4:0] entry_count, [36:5] out_key, [68:37] out_payload, [71:69] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // [1:0] status
  output logic [STATUS_W-1:0]   m_axis_tuser_o,
  output logic                  m_axis_tlast_o
);

  localparam int unsigned OccW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (OccW > COUNT_W + 1) ? OccW : COUNT_W + 1;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_APPLY   = 4'b0010,
    S_READ    = 4'b0100,
    S_RESTORE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [OccW-1:0] occ_q, occ_d;
  logic [OccW-1:0] rot_q, rot_d;
  op_e             op_q;
  logic signed [KEY_W-1:0] key_q;
  logic        [PAY_W-1:0] pay_q;

  logic                    out_valid_q;
  status_e                 out_status_q, out_status_d;
  logic [COUNT_W-1:0]      out_count_q, out_count_d;
  logic signed [KEY_W-1:0] out_key_q, out_key_d;
  logic [PAY_W-1:0]        out_pay_q, out_pay_d;
  logic                    out_last_q, out_last_d;
  logic                    out_load;
  logic                    out_free;

  logic                    accept;
  cell_ctrl_t              ctrl;
  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic [PAY_W-1:0]        cell_pay [CAPACITY];
  logic [CAPACITY-1:0]     cell_ge;
  logic [CAPACITY-1:0]     cell_past;
  logic                    found;
  logic [CmpW-1:0]         occ_w;
  logic [CmpW-1:0]         n_m1;
  logic                    read_last;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign found           = cell_past[CAPACITY-1];

  assign occ_w     = CmpW'(occ_q);
  assign n_m1      = (occ_w >= CmpW'(MAX_RESULTS)) ? CmpW'(MAX_RESULTS - 1) : occ_w - 1'b1;
  assign read_last = (CmpW'(rot_q) == n_m1);

  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    rot_d        = rot_q;
    ctrl.capture = accept;
    ctrl.op      = CELL_HOLD;
    out_load     = 1'b0;
    out_status_d = ST_OK;
    out_count_d  = COUNT_W'(occ_q);
    out_key_d    = '0;
    out_pay_d    = '0;
    out_last_d   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        case (op_q)
          OP_INSERT: begin
            if (out_free) begin
              out_load = 1'b1;
              state_d  = S_IDLE;
              if (occ_q >= OccW'(CAPACITY)) begin
                out_status_d = ST_FULL;
              end else begin
                ctrl.op     = CELL_INSERT;
                occ_d       = occ_q + 1'b1;
                out_count_d = COUNT_W'(occ_d);
              end
            end
          end
          OP_DELETE: begin
            if (out_free) begin
              out_load = 1'b1;
              state_d  = S_IDLE;
              if (occ_q == '0) begin
                out_status_d = ST_EMPTY;
              end else if (!found) begin
                out_status_d = ST_NOT_FOUND;
              end else begin
                ctrl.op     = CELL_DELETE;
                occ_d       = occ_q - 1'b1;
                out_count_d = COUNT_W'(occ_d);
              end
            end
          end
          OP_SEARCH: begin
            if (out_free) begin
              out_load = 1'b1;
              state_d  = S_IDLE;
              if (occ_q == '0) begin
                out_status_d = ST_EMPTY;
              end else if (!found) begin
                out_status_d = ST_NOT_FOUND;
              end
            end
          end
          OP_CLEAR: begin
            if (out_free) begin
              out_load = 1'b1;
              state_d  = S_IDLE;
              if (occ_q == '0) begin
                out_status_d = ST_EMPTY;
              end else begin
                occ_d       = '0;
                out_count_d = '0;
              end
            end
          end
          OP_READ: begin
            if (occ_q == '0) begin
              if (out_free) begin
                out_load     = 1'b1;
                out_status_d = ST_EMPTY;
                state_d      = S_IDLE;
              end
            end else begin
              rot_d   = '0;
              state_d = S_READ;
            end
          end
          default: begin
            // unknown operation: drop it without a result
            state_d = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_key_d  = cell_key[0];
          out_pay_d  = cell_pay[0];
          out_last_d = read_last;
          ctrl.op    = CELL_ROTATE;
          rot_d      = rot_q + 1'b1;
          if (read_last) begin
            state_d = (rot_q == OccW'(CAPACITY - 1)) ? S_IDLE : S_RESTORE;
          end
        end
      end
      S_RESTORE: begin
        // advance the ring until every entry is back in its slot
        ctrl.op = CELL_ROTATE;
        rot_d   = rot_q + 1'b1;
        if (rot_q == OccW'(CAPACITY - 1)) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      rot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      rot_q   <= rot_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(s_axis_tuser_i);
      key_q <= s_axis_tdata_i[KEY_W-1:0];
      pay_q <= s_axis_tdata_i[KEY_W+PAY_W-1:KEY_W];
    end
    if (out_load) begin
      out_status_q <= out_status_d;
      out_count_q  <= out_count_d;
      out_key_q    <= out_key_d;
      out_pay_q    <= out_pay_d;
      out_last_q   <= out_last_d;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int unsigned Left  = (i == 0) ? CAPACITY - 1 : i - 1;
    localparam int unsigned Right = (i == CAPACITY - 1) ? 0 : i + 1;
    logic prev_ge;
    logic prev_past;

    if (i == 0) begin : g_head
      assign prev_ge   = 1'b0;
      assign prev_past = 1'b0;
    end else begin : g_body
      assign prev_ge   = cell_ge[i-1];
      assign prev_past = cell_past[i-1];
    end

    skt_cell #(
      .OccW (OccW),
      .IDX  (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ_q),
      .cmp_key_i   (s_axis_tdata_i[KEY_W-1:0]),
      .new_key_i   (key_q),
      .new_pay_i   (pay_q),
      .left_key_i  (cell_key[Left]),
      .left_pay_i  (cell_pay[Left]),
      .right_key_i (cell_key[Right]),
      .right_pay_i (cell_pay[Right]),
      .prev_ge_i   (prev_ge),
      .prev_past_i (prev_past),
      .key_o       (cell_key[i]),
      .pay_o       (cell_pay[i]),
      .ge_o        (cell_ge[i]),
      .past_o      (cell_past[i])
    );
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - OUT_FLD_W){1'b0}}, out_pay_q, out_key_q, out_count_q};

endmodule

`default_nettype wire

// ----- rtl/skt_cell.sv -----
// One entry of the sorted table: key, payload and compare flags.
`default_nettype none

module skt_cell import skt_pkg::*; #(
  parameter int unsigned OccW = 5,
  parameter int unsigned IDX  = 0
) (
  input  wire                     clk_i,
  input  cell_ctrl_t              ctrl_i,
  input  wire        [OccW-1:0]   occ_i,
  input  wire signed [KEY_W-1:0]  cmp_key_i,
  input  wire signed [KEY_W-1:0]  new_key_i,
  input  wire        [PAY_W-1:0]  new_pay_i,
  input  wire signed [KEY_W-1:0]  left_key_i,
  input  wire        [PAY_W-1:0]  left_pay_i,
  input  wire signed [KEY_W-1:0]  right_key_i,
  input  wire        [PAY_W-1:0]  right_pay_i,
  input  wire                     prev_ge_i,
  input  wire                     prev_past_i,
  output logic signed [KEY_W-1:0] key_o,
  output logic        [PAY_W-1:0] pay_o,
  output logic                    ge_o,
  output logic                    past_o
);

  localparam bit IsHead = (IDX == 0);

  logic signed [KEY_W-1:0] key_q, key_d;
  logic        [PAY_W-1:0] pay_q, pay_d;
  logic                    less_q, match_q;
  logic                    occupied;

  assign occupied = (occ_i > OccW'(IDX));

  // an equal head key pushes the new entry to the second slot
  assign ge_o   = IsHead ? (!less_q && !match_q) : !less_q;
  assign past_o = prev_past_i || match_q;
  assign key_o  = key_q;
  assign pay_o  = pay_q;

  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (ge_o) begin
          if (prev_ge_i) begin
            key_d = left_key_i;
            pay_d = left_pay_i;
          end else begin
            key_d = new_key_i;
            pay_d = new_pay_i;
          end
        end
      end
      CELL_DELETE: begin
        if (past_o) begin
          key_d = right_key_i;
          pay_d = right_pay_i;
        end
      end
      CELL_ROTATE: begin
        key_d = right_key_i;
        pay_d = right_pay_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
    if (ctrl_i.capture) begin
      less_q  <= occupied && (key_q < cmp_key_i);
      match_q <= occupied && (key_q == cmp_key_i);
    end
  end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking stream testbench for the sorted key table unit.
`timescale 1ns / 100ps

module testbench;
  import skt_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned RANDOM_CMDS    = 360;
  localparam int unsigned HOLD_AT_REPLY  = 60;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 2 * CAPACITY_DEF + 8;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        pay;
  } table_cmd_t;

  typedef struct {
    status_e                 status;
    logic [COUNT_W-1:0]      count;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        pay;
    logic                    last;
  } table_reply_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [OP_W-1:0]       s_tuser = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [STATUS_W-1:0]   m_axis_tuser_o;
  logic                  m_axis_tlast_o;

  // shadow of the table contents
  logic signed [KEY_W-1:0] tbl_key [CAPACITY_DEF];
  logic [PAY_W-1:0]        tbl_pay [CAPACITY_DEF];
  int                      tbl_count = 0;

  table_cmd_t   cmd_backlog [$];
  table_reply_t replies_due [$];
  table_cmd_t   cmd_on_bus;

  int err_count    = 0;
  int gap_left     = 0;
  int stall_left   = 0;
  int hold_left    = 0;
  int replies_seen = 0;
  int idle_cycles  = 0;
  bit send_burst   = 1'b0;
  bit take_burst   = 1'b0;

  logic signed [KEY_W-1:0] key_pool [12];

  always #5 clk_i = ~clk_i;

  sorted_key_table_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  function automatic void expect_reply(status_e st, logic signed [KEY_W-1:0] k,
                                       logic [PAY_W-1:0] p, logic lst);
    table_reply_t r;
    r.status = st;
    r.count  = COUNT_W'(tbl_count);
    r.key    = k;
    r.pay    = p;
    r.last   = lst;
    replies_due.push_back(r);
  endfunction

  function automatic int find_entry(logic signed [KEY_W-1:0] k);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_key[i] == k) return i;
    end
    return -1;
  endfunction

  // update the shadow table and queue the replies one request causes
  function automatic void apply_table_op(table_cmd_t c);
    int lt;
    int pos;
    int hit;
    int n;
    case (c.op)
      OP_INSERT: begin
        if (tbl_count >= CAPACITY_DEF) begin
          expect_reply(ST_FULL, '0, '0, 1'b1);
        end else begin
          lt = 0;
          for (int i = 0; i < tbl_count; i++) begin
            if (tbl_key[i] < c.key) lt++;
          end
          // a key equal to the head lands right behind the head
          if (tbl_count == 0 || c.key < tbl_key[0]) pos = 0;
          else pos = (lt < 1) ? 1 : lt;
          for (int i = tbl_count; i > pos; i--) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_pay[i] = tbl_pay[i-1];
          end
          tbl_key[pos] = c.key;
          tbl_pay[pos] = c.pay;
          tbl_count++;
          expect_reply(ST_OK, '0, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        hit = find_entry(c.key);
        if (tbl_count == 0) begin
          expect_reply(ST_EMPTY, '0, '0, 1'b1);
        end else if (hit < 0) begin
          expect_reply(ST_NOT_FOUND, '0, '0, 1'b1);
        end else begin
          for (int i = hit; i + 1 < tbl_count; i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_pay[i] = tbl_pay[i+1];
          end
          tbl_count--;
          expect_reply(ST_OK, '0, '0, 1'b1);
        end
      end
      OP_SEARCH: begin
        if (tbl_count == 0) expect_reply(ST_EMPTY, '0, '0, 1'b1);
        else if (find_entry(c.key) >= 0) expect_reply(ST_OK, '0, '0, 1'b1);
        else expect_reply(ST_NOT_FOUND, '0, '0, 1'b1);
      end
      OP_CLEAR: begin
        if (tbl_count == 0) begin
          expect_reply(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          tbl_count = 0;
          expect_reply(ST_OK, '0, '0, 1'b1);
        end
      end
      OP_READ: begin
        if (tbl_count == 0) begin
          expect_reply(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          n = (tbl_count < MAX_RESULTS) ? tbl_count : MAX_RESULTS;
          for (int i = 0; i < n; i++) begin
            expect_reply(ST_OK, tbl_key[i], tbl_pay[i], i == n - 1);
          end
        end
      end
      default: ;  // unknown codes are dropped without a reply
    endcase
  endfunction

  function automatic void queue_cmd(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] k,
                                    logic [PAY_W-1:0] p);
    table_cmd_t c;
    c.op  = op;
    c.key = k;
    c.pay = p;
    cmd_backlog.push_back(c);
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, 11)];
    return $urandom;
  endfunction

  // request driver
  always @(posedge clk_i) begin : drive_proc
    table_cmd_t nxt;
    int gap;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_axis_tready_o) begin
        apply_table_op(cmd_on_bus);
        if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 8);
        if (gap == 0 && cmd_backlog.size() > 0) begin
          // keep valid high and present the next request
          nxt = cmd_backlog.pop_front();
          cmd_on_bus <= nxt;
          s_tdata    <= {nxt.pay, nxt.key};
          s_tuser    <= nxt.op;
        end else begin
          s_tvalid <= 1'b0;
          gap_left = (gap > 0) ? gap - 1 : 0;
        end
      end else if (!s_tvalid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() > 0) begin
          nxt = cmd_backlog.pop_front();
          cmd_on_bus <= nxt;
          s_tdata    <= {nxt.pay, nxt.key};
          s_tuser    <= nxt.op;
          s_tvalid   <= 1'b1;
        end
      end
    end
  end

  // reply monitor and receiver stalls
  always @(posedge clk_i) begin : collect_proc
    table_reply_t exp_r;
    logic [COUNT_W-1:0]      got_count;
    logic signed [KEY_W-1:0] got_key;
    logic [PAY_W-1:0]        got_pay;
    logic                    ready_nxt;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_tready) begin
        got_count = m_axis_tdata_o[COUNT_W-1:0];
        got_key   = m_axis_tdata_o[COUNT_W +: KEY_W];
        got_pay   = m_axis_tdata_o[COUNT_W + KEY_W +: PAY_W];
        if (replies_due.size() == 0) begin
          $error("reply with none expected: status %0d count %0d", m_axis_tuser_o,
                 got_count);
          err_count++;
        end else begin
          exp_r = replies_due.pop_front();
          if (m_axis_tuser_o !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, m_axis_tuser_o);
            err_count++;
          end
          if (got_count !== exp_r.count) begin
            $error("entry_count: expected %0d, got %0d", exp_r.count, got_count);
            err_count++;
          end
          if (got_key !== exp_r.key) begin
            $error("out_key: expected %0d, got %0d", exp_r.key, got_key);
            err_count++;
          end
          if (got_pay !== exp_r.pay) begin
            $error("out_payload: expected %0h, got %0h", exp_r.pay, got_pay);
            err_count++;
          end
          if (m_axis_tlast_o !== exp_r.last) begin
            $error("last: expected %0b, got %0b", exp_r.last, m_axis_tlast_o);
            err_count++;
          end
        end
        replies_seen++;
        // one long hold-off so the table backs up into the request side
        if (replies_seen == HOLD_AT_REPLY) hold_left = HOLD_CYCLES;
        if ($urandom_range(0, 39) == 0) take_burst = ~take_burst;
        stall_left = take_burst ? 0 : $urandom_range(0, 8);
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_nxt = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_nxt = 1'b0;
      end else begin
        ready_nxt = 1'b1;
      end
      m_tready <= ready_nxt;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus_proc
    int made;
    int r;
    logic [OP_W-1:0] op;

    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = 0;
    key_pool[3] = -1;
    for (int i = 4; i < 12; i++) key_pool[i] = $urandom;

    // directed: empty table cases
    queue_cmd(OP_READ,   0, 0);
    queue_cmd(OP_SEARCH, 5, 0);
    queue_cmd(OP_DELETE, 5, 0);
    queue_cmd(OP_CLEAR,  0, 0);
    // fill up, with duplicates of the head key and both key extremes
    queue_cmd(OP_INSERT, 0, 32'h0000_0000);
    queue_cmd(OP_INSERT, 0, 32'h0000_0001);
    queue_cmd(OP_INSERT, 32'sh8000_0000, 32'hffff_ffff);
    queue_cmd(OP_INSERT, 32'sh8000_0000, 32'h0000_0002);
    queue_cmd(OP_INSERT, 32'sh7fff_ffff, 32'ha5a5_a5a5);
    queue_cmd(OP_INSERT, -1, 32'h5a5a_5a5a);
    queue_cmd(OP_INSERT, 32'sh7fff_ffff, 32'h0000_0003);
    for (int i = 0; i < 9; i++) queue_cmd(OP_INSERT, $urandom_range(0, 4) - 2, $urandom);
    queue_cmd(OP_INSERT, 7, 32'hdead_0001);  // refused, table full
    queue_cmd(OP_SEARCH, 0, 0);
    queue_cmd(OP_SEARCH, 32'sh1234_5678, 0);
    queue_cmd(OP_DELETE, 32'sh8000_0000, 0);  // only the first match goes
    queue_cmd(OP_DELETE, 32'sh1234_5678, 0);
    queue_cmd(OP_READ,   0, 0);
    queue_cmd(3'd7, 32'hffff_ffff, 32'hffff_ffff);  // dropped
    queue_cmd(OP_CLEAR,  0, 0);

    // random: mostly a small key pool so deletes and searches hit
    made = 0;
    while (made < RANDOM_CMDS) begin
      r = $urandom_range(0, 99);
      if (r < 40) op = OP_INSERT;
      else if (r < 60) op = OP_DELETE;
      else if (r < 78) op = OP_SEARCH;
      else if (r < 90) op = OP_READ;
      else if (r < 94) op = OP_CLEAR;
      else op = $urandom_range(5, 7);
      queue_cmd(op, pick_key(), $urandom);
      if (op <= OP_READ) made++;
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_backlog.size() != 0 || s_tvalid) @(negedge clk_i);
    while (replies_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
